// ----- rtl/core/pila_pkg.sv -----
package pila_pkg;

    // Width of the index fields on the channels.
    localparam int FIELD_BITS = 32;

    // Most words one vertex can cause (an outlined quad) and the width of a word count.
    localparam int MAX_WORDS  = 8;
    localparam int COUNT_BITS = 4;
    localparam int PTR_BITS   = 3;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PRIMITIVE_TYPE      = 2'd0,
        CFG_OUTLINE_MODE        = 2'd1,
        CFG_LAST_VERTEX_PROVOKES = 2'd2,
        CFG_FLAT_SHADE          = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        PRIM_POINTS     = 4'd0,
        PRIM_LINES      = 4'd1,
        PRIM_LINE_STRIP = 4'd2,
        PRIM_LINE_LOOP  = 4'd3,
        PRIM_TRIS       = 4'd4,
        PRIM_TRI_STRIP  = 4'd5,
        PRIM_TRI_FAN    = 4'd6,
        PRIM_QUADS      = 4'd7,
        PRIM_QUAD_STRIP = 4'd8,
        PRIM_POLYGON    = 4'd9
    } prim_t;

    typedef struct packed {
        prim_t prim_type;
        logic  outline_mode;
        logic  last_vertex_provokes;
        logic  flat_shade;
    } cfg_t;

endpackage

// ----- rtl/core/pila_in_if.sv -----
interface pila_in_if;
    logic                             valid;
    logic                             ready;
    logic [pila_pkg::FIELD_BITS-1:0]  vertex_index;
    logic                             batch_end;

    modport source (output valid, output vertex_index, output batch_end, input ready);
    modport sink   (input valid, input vertex_index, input batch_end, output ready);
endinterface

// ----- rtl/core/pila_out_if.sv -----
interface pila_out_if;
    logic                             valid;
    logic                             ready;
    logic [pila_pkg::FIELD_BITS-1:0]  out_index;
    logic                             run_last;

    modport source (output valid, output out_index, output run_last, input ready);
    modport sink   (input valid, input out_index, input run_last, output ready);
endinterface

// ----- rtl/core/pila_assemble.sv -----
// Assembly state and the combinational list builder for one vertex.
module pila_assemble #(
    parameter int INDEX_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic [INDEX_BITS-1:0]               cur,
    input  logic                                batch_end,
    input  pila_pkg::cfg_t                      cfg,
    output logic [INDEX_BITS-1:0]               words [pila_pkg::MAX_WORDS],
    output logic [pila_pkg::COUNT_BITS-1:0]     count
);

    typedef logic [1:0][INDEX_BITS-1:0] pair_t;
    typedef logic [2:0][INDEX_BITS-1:0] triple_t;

    logic [INDEX_BITS-1:0] p0_reg, p1_reg, p2_reg, first_reg;
    logic [1:0]            fill_reg, fill_next;
    logic [1:0]            phase_reg, phase_next;
    logic                  odd_reg, odd_next;
    logic [1:0]            ph_new;
    logic                  odd_new;
    logic [INDEX_BITS-1:0] first;

    // Put the provoking corner first while keeping the cyclic order.
    function automatic pair_t line_pv(input logic [INDEX_BITS-1:0] a,
                                      input logic [INDEX_BITS-1:0] b,
                                      input logic [INDEX_BITS-1:0] p);
        pair_t r;
        if (p == a) begin
            r[0] = a; r[1] = b;
        end else begin
            r[0] = b; r[1] = a;
        end
        return r;
    endfunction

    function automatic triple_t tri_pv(input logic [INDEX_BITS-1:0] a,
                                       input logic [INDEX_BITS-1:0] b,
                                       input logic [INDEX_BITS-1:0] c,
                                       input logic [INDEX_BITS-1:0] p);
        triple_t r;
        if (p == a) begin
            r[0] = a; r[1] = b; r[2] = c;
        end else if (p == b) begin
            r[0] = b; r[1] = c; r[2] = a;
        end else begin
            r[0] = c; r[1] = a; r[2] = b;
        end
        return r;
    endfunction

    always_comb
    begin
        pair_t   l0;
        pair_t   l1;
        triple_t t0;
        logic    lp;
        logic    fs;
        logic    ol;
        lp = cfg.last_vertex_provokes;
        fs = cfg.flat_shade;
        ol = cfg.outline_mode;
        first   = (fill_reg == 2'd0) ? cur : first_reg;
        words   = '{default: '0};
        count   = '0;
        ph_new  = phase_reg;
        odd_new = odd_reg;
        l0 = '0;
        l1 = '0;
        t0 = '0;
        case (cfg.prim_type)
            pila_pkg::PRIM_LINES, pila_pkg::PRIM_TRIS:
            begin
                if (!(lp && fs)) begin
                    words[0] = cur;
                    count    = 4'd1;
                end else if (cfg.prim_type == pila_pkg::PRIM_LINES) begin
                    if (phase_reg == 2'd1) begin
                        l0 = line_pv(p0_reg, cur, cur);
                        words[0] = l0[0]; words[1] = l0[1];
                        count = 4'd2;
                    end
                    ph_new = (phase_reg == 2'd1) ? 2'd0 : 2'd1;
                end else begin
                    if (phase_reg == 2'd2) begin
                        t0 = tri_pv(p1_reg, p0_reg, cur, cur);
                        words[0] = t0[0]; words[1] = t0[1]; words[2] = t0[2];
                        count = 4'd3;
                    end
                    ph_new = (phase_reg >= 2'd2) ? 2'd0 : phase_reg + 2'd1;
                end
            end
            pila_pkg::PRIM_LINE_STRIP, pila_pkg::PRIM_LINE_LOOP:
            begin
                if (fill_reg != 2'd0) begin
                    l0 = line_pv(p0_reg, cur, lp ? cur : p0_reg);
                    words[0] = l0[0]; words[1] = l0[1];
                    count = 4'd2;
                    if (cfg.prim_type == pila_pkg::PRIM_LINE_LOOP && batch_end) begin
                        l1 = line_pv(cur, first, lp ? first : cur);
                        words[2] = l1[0]; words[3] = l1[1];
                        count = 4'd4;
                    end
                end
            end
            pila_pkg::PRIM_TRI_STRIP:
            begin
                if (fill_reg[1]) begin
                    if (odd_reg) begin
                        t0 = tri_pv(p0_reg, p1_reg, cur, lp ? cur : p1_reg);
                    end else begin
                        t0 = tri_pv(p1_reg, p0_reg, cur, lp ? cur : p1_reg);
                    end
                    words[0] = t0[0]; words[1] = t0[1]; words[2] = t0[2];
                    count   = 4'd3;
                    odd_new = ~odd_reg;
                end
            end
            pila_pkg::PRIM_TRI_FAN:
            begin
                if (fill_reg[1]) begin
                    t0 = tri_pv(first, p0_reg, cur, lp ? cur : p0_reg);
                    words[0] = t0[0]; words[1] = t0[1]; words[2] = t0[2];
                    count = 4'd3;
                end
            end
            pila_pkg::PRIM_QUADS:
            begin
                if (phase_reg == 2'd3) begin
                    if (ol) begin
                        words = '{p2_reg, p1_reg, p1_reg, p0_reg, p0_reg, cur, cur, p2_reg};
                        count = 4'd8;
                    end else if (fs) begin
                        words[0] = cur;    words[1] = p2_reg; words[2] = p1_reg;
                        words[3] = cur;    words[4] = p1_reg; words[5] = p0_reg;
                        count = 4'd6;
                    end else begin
                        words[0] = p2_reg; words[1] = p1_reg; words[2] = p0_reg;
                        words[3] = p2_reg; words[4] = p0_reg; words[5] = cur;
                        count = 4'd6;
                    end
                end
                ph_new = phase_reg + 2'd1;
            end
            pila_pkg::PRIM_QUAD_STRIP:
            begin
                if (phase_reg[0] && fill_reg == 2'd3) begin
                    if (ol) begin
                        words = '{p2_reg, p1_reg, p1_reg, cur, cur, p0_reg, p0_reg, p2_reg};
                        count = 4'd8;
                    end else if (fs) begin
                        words[0] = cur;    words[1] = p0_reg; words[2] = p2_reg;
                        words[3] = cur;    words[4] = p2_reg; words[5] = p1_reg;
                        count = 4'd6;
                    end else begin
                        words[0] = p2_reg; words[1] = p1_reg; words[2] = p0_reg;
                        words[3] = p0_reg; words[4] = p1_reg; words[5] = cur;
                        count = 4'd6;
                    end
                end
                ph_new = {1'b0, ~phase_reg[0]};
            end
            pila_pkg::PRIM_POLYGON:
            begin
                if (ol) begin
                    if (fill_reg != 2'd0) begin
                        words[0] = p0_reg; words[1] = cur;
                        count = 4'd2;
                        if (batch_end) begin
                            words[2] = cur; words[3] = first;
                            count = 4'd4;
                        end
                    end
                end else if (fill_reg[1]) begin
                    words[0] = first; words[1] = p0_reg; words[2] = cur;
                    count = 4'd3;
                end
            end
            default:
            begin
                // Points and the unused type codes pass each index through.
                words[0] = cur;
                count    = 4'd1;
            end
        endcase
    end

    always_comb
    begin
        if (batch_end) begin
            fill_next  = 2'd0;
            phase_next = 2'd0;
            odd_next   = 1'b0;
        end else begin
            fill_next  = (fill_reg == 2'd3) ? 2'd3 : fill_reg + 2'd1;
            phase_next = ph_new;
            odd_next   = odd_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p0_reg    <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
            first_reg <= '0;
            fill_reg  <= '0;
            phase_reg <= '0;
            odd_reg   <= 1'b0;
        end else if (step) begin
            p2_reg    <= p1_reg;
            p1_reg    <= p0_reg;
            p0_reg    <= cur;
            first_reg <= first;
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
            odd_reg   <= odd_next;
        end
    end

endmodule

// ----- rtl/core/primitive_index_list_assembler_core.sv -----
// Primitive index list assembler.
// The vertices channel takes one vertex index per word, with batch_end set on
// the last vertex of a batch. The indices channel returns the plain point, line
// or triangle list for the configured primitive type, one index per word, and
// run_last marks the final word caused by a given vertex. Vertices that close
// no primitive cause no words at all.
// An accepted vertex is held in the input register, is expanded into the
// list buffer once that buffer is free, and its index words are then offered
// from the list buffer, which drains over the single indices port, one word
// per cycle while the receiver is ready. A vertex causes 1 word for points,
// 2 per line strip vertex, 3 per strip or fan triangle, 6 or 8 on a closing
// quad vertex. A vertex is accepted in the same cycle that the last word of
// the previous list is taken.
// Reset (rst_n low, asynchronous) clears the configuration to points with all
// modes off, empties both registers and clears the assembly state. When the
// receiver stalls, the current word holds and the vertices channel backs up
// after one more vertex has been captured. Configuration writes are taken at
// any edge with cfg_we high and must only happen while the block is idle.
module primitive_index_list_assembler_core #(
    parameter int INDEX_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    pila_in_if.sink                               vertices,
    pila_out_if.source                            indices,
    input  logic                                  cfg_we,
    input  logic [pila_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [pila_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    pila_pkg::cfg_t cfg_reg;

    // Input register.
    logic                  in_vld_reg;
    logic [INDEX_BITS-1:0] in_idx_reg;
    logic                  in_end_reg;

    // List buffer that the indices port drains.
    logic [INDEX_BITS-1:0]           list_mem_reg [pila_pkg::MAX_WORDS];
    logic                            list_vld_reg;
    logic [pila_pkg::COUNT_BITS-1:0] list_len_reg;
    logic [pila_pkg::PTR_BITS-1:0]   rd_ptr_reg;

    logic [INDEX_BITS-1:0]           gen_words [pila_pkg::MAX_WORDS];
    logic [pila_pkg::COUNT_BITS-1:0] gen_count;

    logic accept_in;
    logic fire_out;
    logic last_word;
    logic list_free;
    logic load;

    assign accept_in = vertices.valid && vertices.ready;
    assign fire_out  = list_vld_reg && indices.ready;
    assign last_word = ({1'b0, rd_ptr_reg} == (list_len_reg - 4'd1));
    assign list_free = !list_vld_reg || (fire_out && last_word);
    assign load      = in_vld_reg && list_free;

    assign vertices.ready    = !in_vld_reg || load;
    assign indices.valid     = list_vld_reg;
    assign indices.out_index = pila_pkg::FIELD_BITS'(list_mem_reg[rd_ptr_reg]);
    assign indices.run_last  = last_word;

    // Configuration registers; an index past the list cannot be encoded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '{pila_pkg::PRIM_POINTS, 1'b0, 1'b0, 1'b0};
        end else if (cfg_we) begin
            case (pila_pkg::cfg_index_t'(cfg_index))
                pila_pkg::CFG_PRIMITIVE_TYPE:
                    cfg_reg.prim_type <= pila_pkg::prim_t'(cfg_wdata);
                pila_pkg::CFG_OUTLINE_MODE:
                    cfg_reg.outline_mode <= cfg_wdata[0];
                pila_pkg::CFG_LAST_VERTEX_PROVOKES:
                    cfg_reg.last_vertex_provokes <= cfg_wdata[0];
                pila_pkg::CFG_FLAT_SHADE:
                    cfg_reg.flat_shade <= cfg_wdata[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else if (accept_in) begin
            in_vld_reg <= 1'b1;
        end else if (load) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in) begin
            in_idx_reg <= vertices.vertex_index[INDEX_BITS-1:0];
            in_end_reg <= vertices.batch_end;
        end
    end

    pila_assemble #(
        .INDEX_BITS (INDEX_BITS)
    ) u_assemble (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (load),
        .cur       (in_idx_reg),
        .batch_end (in_end_reg),
        .cfg       (cfg_reg),
        .words     (gen_words),
        .count     (gen_count)
    );

    // A vertex that causes no words leaves the buffer empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            list_vld_reg <= 1'b0;
            list_len_reg <= '0;
            rd_ptr_reg   <= '0;
        end else if (load) begin
            list_vld_reg <= (gen_count != 4'd0);
            list_len_reg <= gen_count;
            rd_ptr_reg   <= '0;
        end else if (fire_out) begin
            if (last_word) begin
                list_vld_reg <= 1'b0;
            end else begin
                rd_ptr_reg <= rd_ptr_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            list_mem_reg <= gen_words;
        end
    end

    a_ptr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        list_vld_reg |-> ({1'b0, rd_ptr_reg} < list_len_reg))
        else $error("read pointer past the end of the list");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        list_vld_reg |-> (list_len_reg != 4'd0 && list_len_reg <= 4'd8))
        else $error("list length out of range");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (fire_out && last_word && !(load && gen_count != 4'd0)) |=> !list_vld_reg)
        else $error("list still offered after its last word was taken");

    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> in_vld_reg)
        else $error("accepted vertex lost from the input register");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (list_vld_reg && !indices.ready) |=> ($stable(rd_ptr_reg) && list_vld_reg))
        else $error("list advanced while the receiver stalled");

endmodule

// ----- bench/primitive_index_list_assembler_checker.sv -----
`timescale 1ns / 100ps

module primitive_index_list_assembler_checker #(
    parameter int INDEX_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    pila_in_if                                  vertices,
    pila_out_if                                 indices,
    input  logic                                cfg_we,
    input  logic [pila_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pila_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output int                                  error_count,
    output int                                  words_outstanding
);

    localparam logic [31:0] IDX_MASK =
        (INDEX_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << INDEX_BITS) - 32'd1);

    typedef struct packed {
        logic [31:0] out_index;
        logic        run_last;
    } index_word_t;

    // Index words still owed by the block, oldest first.
    index_word_t expected_indices[$];

    // Local copy of the configuration registers.
    logic [3:0]  prim_cfg;
    logic        outline_cfg;
    logic        last_provokes_cfg;
    logic        flat_cfg;

    // Assembly state.
    logic [31:0] recent [3];
    logic [31:0] batch_first;
    int          seen_count;
    logic [1:0]  phase;
    logic        odd_tri;

    function automatic void push_index(input logic [31:0] v);
        index_word_t w;
        w.out_index = v & IDX_MASK;
        w.run_last  = 1'b0;
        expected_indices.push_back(w);
    endfunction

    function automatic void push_line(input logic [31:0] a, input logic [31:0] b);
        push_index(a);
        push_index(b);
    endfunction

    function automatic void push_tri(input logic [31:0] a, input logic [31:0] b,
                                     input logic [31:0] c);
        push_index(a);
        push_index(b);
        push_index(c);
    endfunction

    // The provoking index is rotated to the front; ties go to the earliest corner.
    function automatic void push_line_pv(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] p);
        if (p == a) push_line(a, b);
        else        push_line(b, a);
    endfunction

    function automatic void push_tri_pv(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] p);
        if (p == a)      push_tri(a, b, c);
        else if (p == b) push_tri(b, c, a);
        else             push_tri(c, a, b);
    endfunction

    function automatic void assemble_vertex(input logic [31:0] raw, input logic end_flag);
        logic [31:0] cur;
        logic [31:0] p0;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] fv;
        logic [1:0]  ph;
        int          n;
        int          start;
        start = expected_indices.size();
        cur   = raw & IDX_MASK;
        p0    = recent[0];
        p1    = recent[1];
        p2    = recent[2];
        n     = seen_count;
        ph    = phase;
        if (n == 0) batch_first = cur;
        fv = batch_first;

        case (prim_cfg)
            pila_pkg::PRIM_LINES, pila_pkg::PRIM_TRIS: begin
                if (!(last_provokes_cfg && flat_cfg)) begin
                    push_index(cur);
                end else if (prim_cfg == pila_pkg::PRIM_LINES) begin
                    if (ph == 2'd1) push_line_pv(p0, cur, cur);
                    phase = (ph == 2'd1) ? 2'd0 : 2'd1;
                end else begin
                    if (ph == 2'd2) push_tri_pv(p1, p0, cur, cur);
                    phase = (ph >= 2'd2) ? 2'd0 : ph + 2'd1;
                end
            end
            pila_pkg::PRIM_LINE_STRIP, pila_pkg::PRIM_LINE_LOOP: begin
                if (n >= 1) push_line_pv(p0, cur, last_provokes_cfg ? cur : p0);
                if (prim_cfg == pila_pkg::PRIM_LINE_LOOP && end_flag && n >= 1)
                    push_line_pv(cur, fv, last_provokes_cfg ? fv : cur);
            end
            pila_pkg::PRIM_TRI_STRIP: begin
                if (n >= 2) begin
                    if (odd_tri) push_tri_pv(p0, p1, cur, last_provokes_cfg ? cur : p1);
                    else         push_tri_pv(p1, p0, cur, last_provokes_cfg ? cur : p1);
                    odd_tri = ~odd_tri;
                end
            end
            pila_pkg::PRIM_TRI_FAN: begin
                if (n >= 2) push_tri_pv(fv, p0, cur, last_provokes_cfg ? cur : p0);
            end
            pila_pkg::PRIM_QUADS: begin
                if (ph == 2'd3) begin
                    if (outline_cfg) begin
                        push_line(p2, p1);
                        push_line(p1, p0);
                        push_line(p0, cur);
                        push_line(cur, p2);
                    end else if (flat_cfg) begin
                        push_tri(cur, p2, p1);
                        push_tri(cur, p1, p0);
                    end else begin
                        push_tri(p2, p1, p0);
                        push_tri(p2, p0, cur);
                    end
                end
                phase = ph + 2'd1;
            end
            pila_pkg::PRIM_QUAD_STRIP: begin
                if (ph[0] && n >= 3) begin
                    if (outline_cfg) begin
                        push_line(p2, p1);
                        push_line(p1, cur);
                        push_line(cur, p0);
                        push_line(p0, p2);
                    end else if (flat_cfg) begin
                        push_tri(cur, p0, p2);
                        push_tri(cur, p2, p1);
                    end else begin
                        push_tri(p2, p1, p0);
                        push_tri(p0, p1, cur);
                    end
                end
                phase = {1'b0, ~ph[0]};
            end
            pila_pkg::PRIM_POLYGON: begin
                if (outline_cfg) begin
                    if (n >= 1) begin
                        push_line(p0, cur);
                        if (end_flag) push_line(cur, fv);
                    end
                end else if (n >= 2) begin
                    push_tri(fv, p0, cur);
                end
            end
            default: push_index(cur);
        endcase

        recent[2] = p1;
        recent[1] = p0;
        recent[0] = cur;
        if (seen_count < 3) seen_count++;
        if (end_flag) begin
            seen_count = 0;
            phase      = 2'd0;
            odd_tri    = 1'b0;
        end
        if (expected_indices.size() > start)
            expected_indices[expected_indices.size()-1].run_last = 1'b1;
    endfunction

    always @(posedge clk) begin
        index_word_t want;
        if (!rst_n) begin
            prim_cfg          = pila_pkg::PRIM_POINTS;
            outline_cfg       = 1'b0;
            last_provokes_cfg = 1'b0;
            flat_cfg          = 1'b0;
            recent[0]         = '0;
            recent[1]         = '0;
            recent[2]         = '0;
            batch_first       = '0;
            seen_count        = 0;
            phase             = 2'd0;
            odd_tri           = 1'b0;
            error_count       = 0;
            expected_indices.delete();
        end else begin
            if (cfg_we) begin
                case (pila_pkg::cfg_index_t'(cfg_index))
                    pila_pkg::CFG_PRIMITIVE_TYPE:       prim_cfg          = cfg_wdata;
                    pila_pkg::CFG_OUTLINE_MODE:         outline_cfg       = cfg_wdata[0];
                    pila_pkg::CFG_LAST_VERTEX_PROVOKES: last_provokes_cfg = cfg_wdata[0];
                    pila_pkg::CFG_FLAT_SHADE:           flat_cfg          = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (indices.valid && indices.ready) begin
                if (expected_indices.size() == 0) begin
                    $display("%0t: unexpected index word %h run_last %b", $time,
                             indices.out_index, indices.run_last);
                    error_count++;
                end else begin
                    want = expected_indices.pop_front();
                    if (indices.out_index !== want.out_index) begin
                        $display("%0t: out_index expected %h actual %h", $time,
                                 want.out_index, indices.out_index);
                        error_count++;
                    end
                    if (indices.run_last !== want.run_last) begin
                        $display("%0t: run_last expected %b actual %b", $time,
                                 want.run_last, indices.run_last);
                        error_count++;
                    end
                end
            end
            if (vertices.valid && vertices.ready)
                assemble_vertex(vertices.vertex_index, vertices.batch_end);
        end
        words_outstanding <= expected_indices.size();
    end

endmodule

// ----- bench/primitive_index_list_assembler_core_test.sv -----
`timescale 1ns / 100ps

module primitive_index_list_assembler_core_test;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [pila_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [pila_pkg::CFG_DATA_BITS-1:0]  cfg_wdata;

    pila_in_if  vertices_bus ();
    pila_out_if indices_bus ();

    // Mismatch count and the number of index words still owed, both from the checker.
    int mismatch_count;
    int words_pending;

    // Random idling on both channels is switched off for one stretch of the run.
    bit idling_on;

    // A nonzero value asks the receiver to hold ready low; the value sets the stall length.
    int stall_cycles_requested;

    primitive_index_list_assembler_core #(
        .INDEX_BITS (32)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vertices  (vertices_bus),
        .indices   (indices_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    primitive_index_list_assembler_checker #(
        .INDEX_BITS (32)
    ) i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .vertices          (vertices_bus),
        .indices           (indices_bus),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .error_count       (mismatch_count),
        .words_outstanding (words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offers one vertex word and returns at the edge where it is accepted. A random
    // idle gap may come first, so gaps land anywhere inside a batch.
    task automatic send_vertex(input logic [31:0] v, input logic end_flag);
        while (idling_on && $urandom_range(99, 0) < 9)
        begin
            vertices_bus.valid <= 1'b0;
            @(posedge clk);
        end
        vertices_bus.valid        <= 1'b1;
        vertices_bus.vertex_index <= v;
        vertices_bus.batch_end    <= end_flag;
        @(posedge clk);
        while (!vertices_bus.ready) @(posedge clk);
    endtask

    // Stops offering and waits until every owed index word has been taken. The
    // extra cycles cover a vertex that causes no words but is still in flight
    // through the input register and the expansion stage.
    task automatic wait_for_drain();
        vertices_bus.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Writes all four registers on consecutive edges with the write enable held high.
    task automatic apply_setting(input logic [3:0] prim, input bit outline,
                                 input bit last_provokes, input bit flat);
        cfg_we    <= 1'b1;
        cfg_index <= pila_pkg::CFG_PRIMITIVE_TYPE;
        cfg_wdata <= prim;
        @(posedge clk);
        cfg_index <= pila_pkg::CFG_OUTLINE_MODE;
        cfg_wdata <= {3'b000, outline};
        @(posedge clk);
        cfg_index <= pila_pkg::CFG_LAST_VERTEX_PROVOKES;
        cfg_wdata <= {3'b000, last_provokes};
        @(posedge clk);
        cfg_index <= pila_pkg::CFG_FLAT_SHADE;
        cfg_wdata <= {3'b000, flat};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver: ready is recomputed at every edge. A requested hold-off is copied
    // into a local counter so that the stall length is counted here, in cycles.
    initial
    begin
        int hold_left;
        hold_left         = 0;
        indices_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_cycles_requested != 0)
            begin
                hold_left              = stall_cycles_requested;
                stall_cycles_requested = 0;
            end
            if (hold_left > 0)
            begin
                indices_bus.ready <= 1'b0;
                hold_left--;
            end
            else if (idling_on && $urandom_range(99, 0) < 9)
                indices_bus.ready <= 1'b0;
            else
                indices_bus.ready <= 1'b1;
        end
    end

    // Watchdog: the slowest correct run is far below this.
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int          random_sent;
        int          phase_left;
        int          batch_len;
        int          unit;
        logic [3:0]  prim;
        bit          outline;
        bit          last_provokes;
        bit          flat;
        bit          stall_done;
        bit          cut_batch;
        logic [31:0] v;

        rst_n                     = 1'b0;
        vertices_bus.valid        = 1'b0;
        vertices_bus.vertex_index = '0;
        vertices_bus.batch_end    = 1'b0;
        cfg_we                    = 1'b0;
        cfg_index                 = pila_pkg::CFG_PRIMITIVE_TYPE;
        cfg_wdata                 = '0;
        idling_on                 = 1'b1;
        stall_cycles_requested    = 0;
        stall_done                = 1'b0;
        random_sent               = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Points after reset, with both extreme index values.
        send_vertex(32'h0000_0000, 1'b0);
        send_vertex(32'hFFFF_FFFF, 1'b1);

        // An unused primitive type behaves like points.
        wait_for_drain();
        apply_setting(4'd15, 1'b1, 1'b1, 1'b1);
        send_vertex(32'h8000_0001, 1'b0);
        send_vertex(32'h7FFF_FFFE, 1'b1);

        // A line loop of one vertex gives nothing; one of three closes on its end.
        wait_for_drain();
        apply_setting(pila_pkg::PRIM_LINE_LOOP, 1'b0, 1'b1, 1'b0);
        send_vertex(32'd42, 1'b1);
        send_vertex(32'd1, 1'b0);
        send_vertex(32'd2, 1'b0);
        send_vertex(32'd3, 1'b1);

        // A fan whose corners repeat the provoking index.
        wait_for_drain();
        apply_setting(pila_pkg::PRIM_TRI_FAN, 1'b0, 1'b1, 1'b0);
        send_vertex(32'd5, 1'b0);
        send_vertex(32'd5, 1'b0);
        send_vertex(32'd5, 1'b0);
        send_vertex(32'd9, 1'b1);

        // An outlined quad, then a flat-shaded quad cut short by its batch end.
        wait_for_drain();
        apply_setting(pila_pkg::PRIM_QUADS, 1'b1, 1'b0, 1'b1);
        send_vertex(32'd10, 1'b0);
        send_vertex(32'd11, 1'b0);
        send_vertex(32'd12, 1'b0);
        send_vertex(32'd13, 1'b1);
        wait_for_drain();
        apply_setting(pila_pkg::PRIM_QUADS, 1'b0, 1'b0, 1'b1);
        send_vertex(32'd10, 1'b0);
        send_vertex(32'd11, 1'b0);
        send_vertex(32'd12, 1'b1);

        // The type changes in mid batch; the assembly state carries over.
        send_vertex(32'd20, 1'b0);
        send_vertex(32'd21, 1'b0);
        wait_for_drain();
        apply_setting(pila_pkg::PRIM_QUAD_STRIP, 1'b0, 1'b1, 1'b1);
        send_vertex(32'd22, 1'b0);
        send_vertex(32'd23, 1'b1);

        // Random part: phases of random settings, each a run of batches. Each
        // phase starts after a full drain, mid-batch if the previous batch was cut short.
        while (random_sent < 385)
        begin
            if ($urandom_range(99, 0) < 8)
                prim = 4'($urandom_range(15, 10));
            else
                prim = 4'($urandom_range(9, 0));
            outline       = 1'($urandom_range(1, 0));
            last_provokes = 1'($urandom_range(1, 0));
            flat          = 1'($urandom_range(1, 0));
            wait_for_drain();
            apply_setting(prim, outline, last_provokes, flat);

            case (prim)
                pila_pkg::PRIM_LINES:      unit = 2;
                pila_pkg::PRIM_TRIS:       unit = 3;
                pila_pkg::PRIM_QUADS:      unit = 4;
                pila_pkg::PRIM_QUAD_STRIP: unit = 2;
                default:                   unit = 1;
            endcase

            phase_left = $urandom_range(40, 15);
            while (phase_left > 0 && random_sent < 385)
            begin
                // Mostly batches of whole primitives; the rest have a ragged length.
                if ($urandom_range(99, 0) < 75)
                    batch_len = unit *
                        $urandom_range(4, (prim == pila_pkg::PRIM_QUAD_STRIP) ? 2 : 1);
                else
                    batch_len = $urandom_range(12, 1);
                cut_batch = ($urandom_range(99, 0) < 10);

                for (int i = 0; i < batch_len; i++)
                begin
                    case ($urandom_range(9, 0))
                        0, 1, 2, 3: v = $urandom();
                        4, 5, 6:    v = $urandom_range(7, 0);
                        7:          v = 32'hFFFF_FFF8 | $urandom_range(7, 0);
                        8:          v = 32'hFFFF_FFFF;
                        default:    v = 32'h0000_0000;
                    endcase
                    send_vertex(v, (i == batch_len - 1) && !cut_batch);
                    random_sent++;
                    phase_left--;

                    // One quiet stretch with no idling on either side.
                    idling_on = !(random_sent >= 150 && random_sent < 250);

                    // Once, the receiver holds off long enough that the block fills
                    // and stalls the vertex channel while words keep being offered.
                    if (!stall_done && random_sent >= 300)
                    begin
                        stall_cycles_requested = 80;
                        stall_done             = 1'b1;
                    end
                end
            end
        end

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && words_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
